/* src/csdm_pkg.sv */
`default_nettype none

package csdm_pkg;

  // Control population and field widths.
  localparam int CONTROL_COUNT = 70;
  localparam int KNOB_COUNT    = 53;
  localparam int IDX_W         = 7;
  localparam int RAW_W         = 10;
  localparam int VAL_W         = 7;
  localparam int CHAN_W        = 5;

  // Group channel register: ten 4-bit fields, each holding channel minus one.
  localparam int GROUP_COUNT   = 10;
  localparam int GROUP_IDX_W   = 4;
  localparam int CHAN_FIELD_W  = 4;
  localparam int CFG_W         = GROUP_COUNT * CHAN_FIELD_W;
  localparam logic [CFG_W-1:0] CFG_RESET = 40'h98_7654_3210;

  // Scaling and thresholds.
  localparam int FULL_SCALE       = 127;
  localparam int ADC_MAX          = 1023;
  localparam int SWITCH_THRESHOLD = 500;
  localparam int DEADBAND         = 2;
  localparam int PROD_W           = RAW_W + VAL_W;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              is_knob;
    logic [VAL_W-1:0]  value;
    logic [CHAN_W-1:0] channel;
  } csdm_item_t;

  // Result word presented on the output.
  typedef struct packed {
    logic [VAL_W-1:0]  control_value;
    logic              value_changed;
    logic [CHAN_W-1:0] channel;
    logic              scan_changed;
    logic              is_knob;
  } csdm_result_t;

  // Fixed assignment of controls to groups.
  function automatic logic [GROUP_IDX_W-1:0] group_of(input logic [IDX_W-1:0] idx);
    logic [GROUP_IDX_W-1:0] grp;
    unique case (idx) inside
      [7'd0:7'd5]:   grp = 4'd0;
      [7'd6:7'd11]:  grp = 4'd1;
      [7'd12:7'd17]: grp = 4'd2;
      [7'd18:7'd23]: grp = 4'd3;
      [7'd24:7'd29]: grp = 4'd4;
      [7'd30:7'd35]: grp = 4'd5;
      [7'd36:7'd41]: grp = 4'd6;
      [7'd42:7'd47]: grp = 4'd7;
      [7'd48:7'd52]: grp = 4'd8;
      [7'd53:7'd69]: grp = 4'd9;
      default:       grp = 4'd0;
    endcase
    return grp;
  endfunction

endpackage

`default_nettype wire

/* src/control_scan_deadband_mapper_unit.sv */
// An accepted word passes a queue entry, the compare stage register and the
// output register. One word per cycle is sustained without output stalls; the
// store's registered read and a forwarding register for the last write let
// consecutive words follow directly. Reset (synchronous, active high) empties
// the queue and pipeline, restores the default group channels, clears the
// scan flag and marks every stored value unwritten; no clearing pass is needed.
`default_nettype none

module control_scan_deadband_mapper_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [csdm_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [csdm_pkg::IDX_W-1:0]    control_index,
  input  wire logic [csdm_pkg::RAW_W-1:0]    raw_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [csdm_pkg::VAL_W-1:0]         control_value,
  output logic                               value_changed,
  output logic [csdm_pkg::CHAN_W-1:0]        channel,
  output logic                               scan_changed,
  output logic                               is_knob
);

  csdm_pkg::csdm_item_t   front_item;
  csdm_pkg::csdm_item_t   q_item;
  logic                   q_valid;
  logic                   q_ready;
  csdm_pkg::csdm_result_t result;

  // Front part: configuration register, scaling and classification.
  csdm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .control_index (control_index),
    .raw_sample    (raw_sample),
    .item          (front_item)
  );

  // Short queue between the two parts.
  csdm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back part: deadband check against the store and result register.
  csdm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign control_value = result.control_value;
  assign value_changed = result.value_changed;
  assign channel       = result.channel;
  assign scan_changed  = result.scan_changed;
  assign is_knob       = result.is_knob;

endmodule

`default_nettype wire

/* src/csdm_front.sv */
`default_nettype none

module csdm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [csdm_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [csdm_pkg::IDX_W-1:0]    control_index,
  input  wire logic [csdm_pkg::RAW_W-1:0]    raw_sample,
  output csdm_pkg::csdm_item_t               item
);

  logic [csdm_pkg::CFG_W-1:0]       group_channels;
  logic [csdm_pkg::PROD_W-1:0]      prod;
  logic [csdm_pkg::VAL_W-1:0]       quot_lo;
  logic [csdm_pkg::RAW_W:0]         rem;
  logic [csdm_pkg::VAL_W-1:0]       knob_val;
  logic [csdm_pkg::VAL_W-1:0]       switch_val;
  logic [csdm_pkg::GROUP_IDX_W-1:0] grp;
  logic [csdm_pkg::CHAN_FIELD_W-1:0] chan_field;
  logic                             in_range;
  logic                             knob;

  // Group channel register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_channels <= csdm_pkg::CFG_RESET;
    end else if (cfg_write) begin
      group_channels <= cfg_data;
    end
  end

  // Knob scaling: raw*127 as a shift and subtract, then divide by 1023.
  // The quotient by 1024 plus one correction step gives the exact result,
  // since the remainder estimate stays below twice the divisor.
  always_comb begin
    prod     = {raw_sample, {csdm_pkg::VAL_W{1'b0}}} - {{csdm_pkg::VAL_W{1'b0}}, raw_sample};
    quot_lo  = prod[csdm_pkg::PROD_W-1:csdm_pkg::RAW_W];
    rem      = {1'b0, prod[csdm_pkg::RAW_W-1:0]}
             + {{(csdm_pkg::RAW_W + 1 - csdm_pkg::VAL_W){1'b0}}, quot_lo};
    knob_val = (rem >= (csdm_pkg::RAW_W + 1)'(csdm_pkg::ADC_MAX))
             ? quot_lo + csdm_pkg::VAL_W'(1) : quot_lo;
  end

  // Switch threshold.
  assign switch_val = (raw_sample > csdm_pkg::RAW_W'(csdm_pkg::SWITCH_THRESHOLD))
                    ? csdm_pkg::VAL_W'(csdm_pkg::FULL_SCALE) : '0;

  // Classification and channel lookup.
  assign in_range   = control_index < csdm_pkg::IDX_W'(csdm_pkg::CONTROL_COUNT);
  assign knob       = control_index < csdm_pkg::IDX_W'(csdm_pkg::KNOB_COUNT);
  assign grp        = csdm_pkg::group_of(control_index);
  assign chan_field = group_channels[grp * csdm_pkg::CHAN_FIELD_W +: csdm_pkg::CHAN_FIELD_W];

  // Out-of-range controls carry value 0 and channel 1.
  always_comb begin
    item.idx      = control_index;
    item.in_range = in_range;
    item.is_knob  = in_range && knob;
    if (!in_range) begin
      item.value   = '0;
      item.channel = csdm_pkg::CHAN_W'(1);
    end else begin
      item.value   = knob ? knob_val : switch_val;
      item.channel = {1'b0, chan_field} + csdm_pkg::CHAN_W'(1);
    end
  end

endmodule

`default_nettype wire

/* src/csdm_queue.sv */
`default_nettype none

module csdm_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire csdm_pkg::csdm_item_t push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output csdm_pkg::csdm_item_t      pop_item
);

  csdm_pkg::csdm_item_t                entries [csdm_pkg::QUEUE_DEPTH];
  logic [csdm_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [csdm_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [csdm_pkg::QUEUE_CNT_W-1:0]    count;
  logic                                push;
  logic                                pop;

  assign push_ready = count != csdm_pkg::QUEUE_CNT_W'(csdm_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + csdm_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + csdm_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + csdm_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - csdm_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/csdm_back.sv */
`default_nettype none

module csdm_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire csdm_pkg::csdm_item_t q_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csdm_pkg::csdm_result_t    out_result
);

  logic [csdm_pkg::VAL_W-1:0]         store [csdm_pkg::CONTROL_COUNT];
  logic [csdm_pkg::CONTROL_COUNT-1:0] stored_valid;
  logic [csdm_pkg::VAL_W-1:0]         rd_data;

  logic                               s2_valid;
  csdm_pkg::csdm_item_t               s2_item;
  logic                               s2_fire;

  logic                               fwd_valid;
  logic [csdm_pkg::IDX_W-1:0]         fwd_idx;
  logic [csdm_pkg::VAL_W-1:0]         fwd_val;

  logic                               scan_flag;
  logic                               scan_flag_next;
  logic                               prev_known;
  logic [csdm_pkg::VAL_W-1:0]         prev_val;
  logic [csdm_pkg::VAL_W-1:0]         diff;
  logic                               changed;

  csdm_pkg::csdm_result_t             result_next;

  // Pipeline advance: the output register frees the compare stage, which
  // in turn frees the read stage.
  assign s2_fire = s2_valid && (!out_valid || out_ready);
  assign q_ready = !s2_valid || s2_fire;

  // Registered read of the last-reported store as a word enters the compare stage.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_item.in_range) begin
      rd_data <= store[q_item.idx];
    end
  end

  // Store write on a reported change.
  always_ff @(posedge clk) begin
    if (s2_fire && changed) begin
      store[s2_item.idx] <= s2_item.value;
    end
  end

  // Compare stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (q_ready) begin
      s2_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      s2_item <= q_item;
    end
  end

  // Previous value: a write made on the same edge as the read is forwarded.
  // An entry never written always counts as a change.
  always_comb begin
    prev_known = s2_item.in_range && stored_valid[s2_item.idx];
    prev_val   = (fwd_valid && fwd_idx == s2_item.idx) ? fwd_val : rd_data;
    diff       = (s2_item.value > prev_val) ? s2_item.value - prev_val
                                            : prev_val - s2_item.value;
    changed    = s2_item.in_range
              && (!prev_known || diff >= csdm_pkg::VAL_W'(csdm_pkg::DEADBAND));
  end

  // Scan flag clears at control 0 before that sample is judged.
  always_comb begin
    if (s2_item.in_range && s2_item.idx == '0) begin
      scan_flag_next = changed;
    end else begin
      scan_flag_next = scan_flag || changed;
    end
  end

  always_comb begin
    result_next.control_value = s2_item.value;
    result_next.value_changed = changed;
    result_next.channel       = s2_item.channel;
    result_next.scan_changed  = scan_flag_next;
    result_next.is_knob       = s2_item.is_knob;
  end

  // Valid flags, forwarding register and scan flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_valid <= '0;
      fwd_valid    <= 1'b0;
      scan_flag    <= 1'b0;
    end else if (s2_fire) begin
      scan_flag <= scan_flag_next;
      if (changed) begin
        stored_valid[s2_item.idx] <= 1'b1;
        fwd_valid                 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && changed) begin
      fwd_idx <= s2_item.idx;
      fwd_val <= s2_item.value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_result <= result_next;
    end
  end

  // A reported change always leaves the scan flag set.
  a_change_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && changed) |=> scan_flag)
    else $error("scan flag not set after a reported change");

  // A changed word never shows a clear scan flag.
  a_result_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.value_changed) |-> out_result.scan_changed)
    else $error("changed word reported without scan flag");

  // The forwarding register tracks the most recent store write.
  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && changed) |=> (fwd_valid && fwd_idx == $past(s2_item.idx)))
    else $error("forwarding register missed a store write");

  // Reset leaves every entry unwritten and the scan flag clear.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (stored_valid == '0 && !scan_flag))
    else $error("store flags not cleared by reset");

endmodule

`default_nettype wire

/* tb/control_scan_deadband_mapper_unit_test.sv */
`timescale 1ns / 100ps

module control_scan_deadband_mapper_unit_test;

  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 212;
  localparam int STALL_LIMIT = 4000;
  localparam int DIRECTED    = 21;

  // One directed row: the sample and, where it is obvious, the word it must produce.
  typedef struct {
    logic [csdm_pkg::IDX_W-1:0] idx;
    logic [csdm_pkg::RAW_W-1:0] raw;
    bit                         typed;
    csdm_pkg::csdm_result_t     word;
  } sample_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [csdm_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [csdm_pkg::IDX_W-1:0]  control_index = '0;
  logic [csdm_pkg::RAW_W-1:0]  raw_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [csdm_pkg::VAL_W-1:0]  control_value;
  logic                        value_changed;
  logic [csdm_pkg::CHAN_W-1:0] channel;
  logic                        scan_changed;
  logic                        is_knob;

  // Flow-control pattern of the current phase.
  bit sender_idle = 1'b0;
  bit receiver_stall = 1'b0;
  int stall_pct = 83;

  // Shadow state of the mapper.
  logic [7:0]                 shadow_level [csdm_pkg::CONTROL_COUNT];
  logic                       shadow_scan_flag;
  logic [csdm_pkg::CFG_W-1:0] shadow_group_map;

  csdm_pkg::csdm_result_t mapped_words [$];
  int           last_raw [128];
  int           samples_sent = 0;
  int           words_checked = 0;
  int           mismatch_count = 0;
  int           outside_count = 0;
  int           change_count = 0;
  int           map_writes = 0;
  int           idle_cycles = 0;

  control_scan_deadband_mapper_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .control_index (control_index),
    .raw_sample    (raw_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .control_value (control_value),
    .value_changed (value_changed),
    .channel       (channel),
    .scan_changed  (scan_changed),
    .is_knob       (is_knob)
  );

  always #5 clk = ~clk;

  // Controls sit in groups of six, then a group of five, then the rest.
  function automatic logic [3:0] control_group(input logic [csdm_pkg::IDX_W-1:0] idx);
    if (idx < 48) begin
      return 4'(idx / 6);
    end
    return (idx < csdm_pkg::KNOB_COUNT) ? 4'd8 : 4'd9;
  endfunction

  // Predicts the word for one sample and advances the shadow state.
  function automatic csdm_pkg::csdm_result_t map_sample(
      input logic [csdm_pkg::IDX_W-1:0] idx,
      input logic [csdm_pkg::RAW_W-1:0] raw);
    int                     value;
    int                     prev;
    int                     diff;
    logic [3:0]             grp;
    csdm_pkg::csdm_result_t word;
    word = '0;
    if (idx >= csdm_pkg::CONTROL_COUNT) begin
      word.channel = csdm_pkg::CHAN_W'(1);
      word.scan_changed = shadow_scan_flag;
      return word;
    end
    if (idx == 0) begin
      shadow_scan_flag = 1'b0;
    end
    if (idx < csdm_pkg::KNOB_COUNT) begin
      value = (int'(raw) * 127) / 1023;
    end else begin
      value = (raw > 500) ? 127 : 0;
    end
    prev = int'(shadow_level[idx]);
    diff = (value > prev) ? value - prev : prev - value;
    if (diff >= 2) begin
      shadow_level[idx] = 8'(value);
      shadow_scan_flag = 1'b1;
      word.value_changed = 1'b1;
    end
    grp = control_group(idx);
    word.control_value = csdm_pkg::VAL_W'(value);
    word.channel = csdm_pkg::CHAN_W'(shadow_group_map[grp*4 +: 4]) + csdm_pkg::CHAN_W'(1);
    word.scan_changed = shadow_scan_flag;
    word.is_knob = (idx < csdm_pkg::KNOB_COUNT);
    return word;
  endfunction

  // Presents one sample, holds it until accepted, then records its word.
  task automatic push_sample(input logic [csdm_pkg::IDX_W-1:0] idx,
                             input logic [csdm_pkg::RAW_W-1:0] raw,
                             input bit typed, input csdm_pkg::csdm_result_t typed_word);
    csdm_pkg::csdm_result_t predicted;
    if (sender_idle && $urandom_range(0, 99) < stall_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < stall_pct);
    end
    in_valid <= 1'b1;
    control_index <= idx;
    raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    predicted = map_sample(idx, raw);
    mapped_words.push_back(typed ? typed_word : predicted);
    samples_sent++;
    if (idx >= csdm_pkg::CONTROL_COUNT) begin
      outside_count++;
    end
    if (predicted.value_changed) begin
      change_count++;
    end
  endtask

  // Stops sending and waits until every pending word has come out.
  task automatic drain_words();
    in_valid <= 1'b0;
    while (mapped_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the group channel map while the block is idle.
  task automatic write_group_map(input logic [csdm_pkg::CFG_W-1:0] map);
    cfg_write <= 1'b1;
    cfg_data <= map;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_group_map = map;
    map_writes++;
    repeat (2) @(posedge clk);
  endtask

  // Receiver: ready every cycle, or stalling part of the time.
  always @(posedge clk) begin
    out_ready <= !(receiver_stall && $urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted word with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    csdm_pkg::csdm_result_t got;
    csdm_pkg::csdm_result_t want;
    bit                     bad;
    if (!rst && out_valid && out_ready) begin
      got = '{control_value, value_changed, channel, scan_changed, is_knob};
      if (mapped_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: value=%0d changed=%0d channel=%0d scan=%0d knob=%0d",
                   got.control_value, got.value_changed, got.channel,
                   got.scan_changed, got.is_knob);
        end
      end else begin
        want = mapped_words.pop_front();
        words_checked++;
        bad = (got.control_value !== want.control_value)
            || (got.value_changed !== want.value_changed)
            || (got.channel !== want.channel)
            || (got.scan_changed !== want.scan_changed)
            || (got.is_knob !== want.is_knob);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("word %0d: expected value=%0d changed=%0d channel=%0d scan=%0d knob=%0d",
                     words_checked, want.control_value, want.value_changed, want.channel,
                     want.scan_changed, want.is_knob);
            $display("word %0d: actual   value=%0d changed=%0d channel=%0d scan=%0d knob=%0d",
                     words_checked, got.control_value, got.value_changed, got.channel,
                     got.scan_changed, got.is_knob);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sample_row_t                rows [DIRECTED];
    logic [csdm_pkg::CFG_W-1:0] map;
    logic [csdm_pkg::IDX_W-1:0] idx;
    logic [csdm_pkg::RAW_W-1:0] raw;
    int                         scan_pos;
    int                         pick;
    int                         level;

    rows = '{
      // First sample after reset always counts as a change.
      '{7'd0,   10'd0,    1'b1, '{7'd0,   1'b1, 5'd1,  1'b1, 1'b1}},
      // Indices past the last control.
      '{7'd127, 10'd1023, 1'b1, '{7'd0,   1'b0, 5'd1,  1'b1, 1'b0}},
      '{7'd70,  10'd0,    1'b1, '{7'd0,   1'b0, 5'd1,  1'b1, 1'b0}},
      // Full scale knobs and switches on both sides of the threshold.
      '{7'd1,   10'd1023, 1'b1, '{7'd127, 1'b1, 5'd1,  1'b1, 1'b1}},
      '{7'd52,  10'd1023, 1'b1, '{7'd127, 1'b1, 5'd9,  1'b1, 1'b1}},
      '{7'd53,  10'd500,  1'b1, '{7'd0,   1'b1, 5'd10, 1'b1, 1'b0}},
      '{7'd69,  10'd501,  1'b1, '{7'd127, 1'b1, 5'd10, 1'b1, 1'b0}},
      // Deadband edges: moves of zero, one and two steps.
      '{7'd0,   10'd8,    1'b0, '0},
      '{7'd0,   10'd9,    1'b0, '0},
      '{7'd0,   10'd17,   1'b0, '0},
      '{7'd1,   10'd1015, 1'b0, '0},
      '{7'd1,   10'd1007, 1'b0, '0},
      '{7'd53,  10'd501,  1'b0, '0},
      '{7'd53,  10'd1023, 1'b0, '0},
      '{7'd53,  10'd500,  1'b0, '0},
      '{7'd0,   10'd0,    1'b0, '0},
      '{7'd71,  10'h2AA,  1'b0, '0},
      '{7'd42,  10'h155,  1'b0, '0},
      '{7'd47,  10'd511,  1'b0, '0},
      '{7'd48,  10'd512,  1'b0, '0},
      '{7'd68,  10'h3FF,  1'b0, '0}
    };

    for (int i = 0; i < csdm_pkg::CONTROL_COUNT; i++) begin
      shadow_level[i] = 8'd255;
    end
    for (int i = 0; i < 128; i++) begin
      last_raw[i] = 512;
    end
    shadow_scan_flag = 1'b0;
    shadow_group_map = csdm_pkg::CFG_RESET;
    scan_pos = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset channel map.
    foreach (rows[i]) begin
      push_sample(rows[i].idx, rows[i].raw, rows[i].typed, rows[i].word);
    end
    drain_words();

    // Random phases, each with its own channel map and flow-control pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: map = '0;
        1: map = '1;
        2: map = csdm_pkg::CFG_RESET;
        default: map = csdm_pkg::CFG_W'({$urandom, $urandom});
      endcase
      write_group_map(map);
      sender_idle = (phase % 4 == 1) || (phase % 4 == 3);
      receiver_stall = (phase % 4 == 2) || (phase % 4 == 3);
      // Idling on both sides at once is light; either side alone is heavy.
      stall_pct = (phase % 4 == 3) ? 14 : 83;
      for (int n = 0; n < PER_PHASE; n++) begin
        // Mostly in-order scans; some stray and out-of-range indices.
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          idx = csdm_pkg::IDX_W'(scan_pos);
          if (scan_pos == csdm_pkg::CONTROL_COUNT - 1 || $urandom_range(0, 31) == 0) begin
            scan_pos = 0;
          end else begin
            scan_pos++;
          end
        end else if (pick < 85) begin
          idx = csdm_pkg::IDX_W'($urandom_range(csdm_pkg::CONTROL_COUNT, 127));
        end else begin
          idx = csdm_pkg::IDX_W'($urandom_range(0, 127));
        end
        // Readings mostly drift near the last one so the deadband is exercised.
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          level = 0;
        end else if (pick == 1) begin
          level = 1023;
        end else if (pick < 5) begin
          level = $urandom_range(0, 1023);
        end else begin
          level = last_raw[idx] + $urandom_range(0, 40) - 20;
          level = (level < 0) ? 0 : (level > 1023) ? 1023 : level;
        end
        last_raw[idx] = level;
        raw = csdm_pkg::RAW_W'(level);
        push_sample(idx, raw, 1'b0, '0);
        // Odd phases also pause halfway until everything has come out.
        if (phase % 2 == 1 && n == PER_PHASE / 2) begin
          drain_words();
        end
      end
      drain_words();
    end

    sender_idle = 1'b0;
    receiver_stall = 1'b0;
    repeat (8) @(posedge clk);

    $display("Sent %0d samples (%0d out of range, %0d value changes) under %0d channel maps.",
             samples_sent, outside_count, change_count, map_writes + 1);
    $display("Checked %0d words across four flow-control patterns; %0d mismatches.",
             words_checked, mismatch_count);
    if (mismatch_count == 0 && mapped_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
